[sv/dmdb_pkg.sv]
// Shared types, codes and constants for the dual motor drive-brake PWM block.
package dmdb_pkg;

  // Command codes carried by the input cmd field
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_DUTY = 2'd1,
    CMD_DIR  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // Generator mode of one motor channel
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LOW    = 2'd1,
    MODE_HIGH   = 2'd2
  } mode_t;

  // Direction codes on the value field
  localparam logic [7:0] DIR_FWD = 8'd0;
  localparam logic [7:0] DIR_BWD = 8'd1;

  // Field widths
  localparam int HP_W    = 16;
  localparam int DUTY_W  = 7;
  localparam int PROD_W  = HP_W + DUTY_W;

  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100);

  // Reset half period: 1000 us period at 40000/32 ticks per ms, halved
  localparam int TICKS_PER_MS  = 40000 / 32;
  localparam int PERIOD_US     = 1000;
  localparam logic [HP_W-1:0] HALF_PERIOD_RESET =
    HP_W'((PERIOD_US * TICKS_PER_MS) / 1000 / 2);

  // floor(x / 100) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x below 2**30 / 76
  localparam int DIV_SHIFT = 30;
  localparam int RECIP_W   = 24;
  localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(((2 ** DIV_SHIFT) + 99) / 100);
  localparam int SCALED_W  = PROD_W + RECIP_W;

  // Input item after the input register, with the pre-multiplied duty product
  typedef struct packed {
    cmd_t              cmd;
    logic [1:0]        motor;
    logic [7:0]        value;
    logic [PROD_W-1:0] prod;
  } item_t;

  // One result item
  typedef struct packed {
    logic left_pwm;
    logic right_pwm;
    logic left_ctl;
    logic right_ctl;
    logic error;
  } result_t;

  // Duty percent saturated to full scale
  function automatic logic [DUTY_W-1:0] duty_sat(input logic [7:0] value);
    logic [DUTY_W-1:0] d;
    if (value > 8'(DUTY_FULL)) begin
      d = DUTY_FULL;
    end else begin
      d = value[DUTY_W-1:0];
    end
    return d;
  endfunction

endpackage

[sv/dual_motor_drive_brake_pwm_top.sv]
// Top level of the two-motor center-aligned drive-brake PWM.
//
// Input channel (in_valid / in_stall): one command per transfer. cmd tick
// steps the shared up-down counter by one; set duty and set direction name a
// motor (0 left, 1 right) and carry the value. Every transfer yields exactly
// one result transfer on out_valid / out_stall with both PWM pins, both
// control pins and the error flag as they stand after that command.
// Configuration: cfg_wr_en writes cfg_wr_data into half_period; write only
// while no command is in flight.
// From input transfer to out_valid a command passes one input register, then
// the state update and result register. Throughput is one command per cycle
// while out_stall is low; the state update is a single pass so commands follow
// back to back. A held result does not block the input register: in_stall
// rises only when both the input register and the result register are
// occupied and out_stall is high.
// Reset (rst_n low, synchronous): counter at zero counting up, all compares
// zero, normal mode, forward, levels low, half_period 625, both stages empty.
module dual_motor_drive_brake_pwm_top #(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [1:0]  in_motor,
  input  logic [7:0]  in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_left_pwm,
  output logic        out_right_pwm,
  output logic        out_left_ctl,
  output logic        out_right_ctl,
  output logic        out_error,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import dmdb_pkg::*;

  logic        adv;
  logic        s1_valid;
  item_t       s1_item;
  logic [15:0] half_period;
  result_t     result;

  // Input register and config register
  dmdb_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_cmd      (in_cmd),
    .in_motor    (in_motor),
    .in_value    (in_value),
    .in_stall    (in_stall),
    .adv         (adv),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s1_valid    (s1_valid),
    .s1_item     (s1_item),
    .half_period (half_period)
  );

  // State update
  dmdb_engine #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (s1_valid && adv),
    .item        (s1_item),
    .half_period (half_period),
    .result      (result)
  );

  // Result register
  dmdb_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_valid      (s1_valid),
    .result        (result),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left_pwm  (out_left_pwm),
    .out_right_pwm (out_right_pwm),
    .out_left_ctl  (out_left_ctl),
    .out_right_ctl (out_right_ctl),
    .out_error     (out_error)
  );

endmodule

[sv/dmdb_in_stage.sv]
// Input register stage: config register, input item register and duty product.
module dmdb_in_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [1:0]             in_cmd,
  input  logic [1:0]             in_motor,
  input  logic [7:0]             in_value,
  output logic                   in_stall,
  input  logic                   adv,
  input  logic                   cfg_wr_en,
  input  logic [15:0]            cfg_wr_data,
  output logic                   s1_valid,
  output dmdb_pkg::item_t        s1_item,
  output logic [15:0]            half_period
);
  import dmdb_pkg::*;

  logic                  valid_r;
  item_t                 item_r;
  logic [HP_W-1:0]       hp_r;
  logic [PROD_W-1:0]     prod_nxt;
  logic                  accept;

  // Stage holds while the result side cannot take its item
  assign in_stall = valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  // half_period * saturated duty, ahead of the divide by 100
  assign prod_nxt = PROD_W'(hp_r) * PROD_W'(duty_sat(in_value));

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r <= HALF_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      hp_r <= cfg_wr_data;
    end
  end

  // Item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd   <= cmd_t'(in_cmd);
      item_r.motor <= in_motor;
      item_r.value <= in_value;
      item_r.prod  <= prod_nxt;
    end
  end

  assign s1_valid    = valid_r;
  assign s1_item     = item_r;
  assign half_period = hp_r;

endmodule

[sv/dmdb_engine.sv]
// PWM state: up-down counter, buffered compare/mode per motor, levels and direction.
module dmdb_engine #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  dmdb_pkg::item_t     item,
  input  logic [15:0]         half_period,
  output dmdb_pkg::result_t   result
);
  import dmdb_pkg::*;

  localparam int CB = COUNTER_BITS;
  localparam int CW = (CB > HP_W) ? CB : HP_W;

  logic [CB-1:0]   cnt_r,  cnt_nxt;
  logic            down_r, down_nxt;
  logic [HP_W-1:0] act_cmp_r  [2];
  logic [HP_W-1:0] act_cmp_nxt[2];
  logic [HP_W-1:0] pend_cmp_r  [2];
  logic [HP_W-1:0] pend_cmp_nxt[2];
  mode_t           act_mode_r  [2];
  mode_t           act_mode_nxt[2];
  mode_t           pend_mode_r  [2];
  mode_t           pend_mode_nxt[2];
  logic [1:0]      bwd_r,  bwd_nxt;
  logic [1:0]      raw_r,  raw_nxt;

  logic [CW-1:0]       hp_w;
  logic [CB-1:0]       top;
  logic [SCALED_W-1:0] scaled;
  logic [HP_W-1:0]     quot;
  logic [DUTY_W-1:0]   duty;
  logic                motor_ok;
  logic                went_up;
  logic                went_down;
  logic                at_zero;
  logic                err;

  // Top value at counter width
  assign hp_w = CW'(half_period);
  assign top  = hp_w[CB-1:0];

  // hp * duty / 100 by reciprocal multiply
  assign scaled = SCALED_W'(item.prod) * SCALED_W'(DIV_RECIP);
  assign quot   = scaled[DIV_SHIFT +: HP_W];
  assign duty   = duty_sat(item.value);

  assign motor_ok = !item.motor[1];

  // Next state for the item in the stage
  always_comb begin
    cnt_nxt       = cnt_r;
    down_nxt      = down_r;
    act_cmp_nxt   = act_cmp_r;
    pend_cmp_nxt  = pend_cmp_r;
    act_mode_nxt  = act_mode_r;
    pend_mode_nxt = pend_mode_r;
    bwd_nxt       = bwd_r;
    raw_nxt       = raw_r;
    went_up       = 1'b0;
    went_down     = 1'b0;
    err           = 1'b0;

    unique case (item.cmd)
      CMD_TICK: begin
        // counter step and turn-around
        if (!down_r) begin
          if (cnt_r < top) begin
            cnt_nxt = cnt_r + 1'b1;
            went_up = 1'b1;
          end
          if (cnt_nxt >= top) begin
            down_nxt = 1'b1;
          end
        end else begin
          if (cnt_r != '0) begin
            cnt_nxt   = cnt_r - 1'b1;
            went_down = 1'b1;
          end
          if (cnt_nxt == '0) begin
            down_nxt = 1'b0;
          end
        end
      end
      CMD_DUTY: begin
        if (!motor_ok) begin
          err = 1'b1;
        end else if (duty == '0) begin
          pend_mode_nxt[item.motor[0]] = MODE_LOW;
        end else if (duty == DUTY_FULL) begin
          pend_mode_nxt[item.motor[0]] = MODE_HIGH;
        end else begin
          pend_mode_nxt[item.motor[0]] = MODE_NORMAL;
          pend_cmp_nxt[item.motor[0]]  = half_period - quot;
        end
      end
      CMD_DIR: begin
        if (!motor_ok) begin
          err = 1'b1;
        end else if (item.value == DIR_FWD) begin
          bwd_nxt[item.motor[0]] = 1'b0;
        end else if (item.value == DIR_BWD) begin
          bwd_nxt[item.motor[0]] = 1'b1;
        end
      end
      CMD_NOP: begin
      end
    endcase

    at_zero = (item.cmd == CMD_TICK) && (cnt_nxt == '0);

    // zero load, then level update per motor
    if (item.cmd == CMD_TICK) begin
      for (int m = 0; m < 2; m++) begin
        if (at_zero) begin
          act_cmp_nxt[m]  = pend_cmp_r[m];
          act_mode_nxt[m] = pend_mode_r[m];
        end
        unique case (act_mode_nxt[m])
          MODE_LOW: begin
            if (at_zero) raw_nxt[m] = 1'b0;
          end
          MODE_HIGH: begin
            if (at_zero) raw_nxt[m] = 1'b1;
          end
          default: begin
            if (CW'(cnt_nxt) == CW'(act_cmp_nxt[m])) begin
              if (went_up) begin
                raw_nxt[m] = 1'b1;
              end else if (went_down) begin
                raw_nxt[m] = 1'b0;
              end
            end
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      down_r <= 1'b0;
      bwd_r  <= '0;
      raw_r  <= '0;
      for (int m = 0; m < 2; m++) begin
        act_cmp_r[m]   <= '0;
        pend_cmp_r[m]  <= '0;
        act_mode_r[m]  <= MODE_NORMAL;
        pend_mode_r[m] <= MODE_NORMAL;
      end
    end else if (go) begin
      cnt_r       <= cnt_nxt;
      down_r      <= down_nxt;
      bwd_r       <= bwd_nxt;
      raw_r       <= raw_nxt;
      act_cmp_r   <= act_cmp_nxt;
      pend_cmp_r  <= pend_cmp_nxt;
      act_mode_r  <= act_mode_nxt;
      pend_mode_r <= pend_mode_nxt;
    end
  end

  // Result reflects the state after this item
  assign result.left_pwm  = raw_nxt[0] ^ bwd_nxt[0];
  assign result.right_pwm = raw_nxt[1] ^ bwd_nxt[1];
  assign result.left_ctl  = bwd_nxt[0];
  assign result.right_ctl = bwd_nxt[1];
  assign result.error     = err;

endmodule

[sv/dmdb_out_stage.sv]
// Result register with valid/stall handshake toward the receiver.
module dmdb_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  dmdb_pkg::result_t   result,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_left_pwm,
  output logic                out_right_pwm,
  output logic                out_left_ctl,
  output logic                out_right_ctl,
  output logic                out_error
);
  import dmdb_pkg::*;

  logic    valid_r;
  result_t res_r;

  // Register is free when empty or when its transfer completes this cycle
  assign adv = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      res_r <= result;
    end
  end

  assign out_valid     = valid_r;
  assign out_left_pwm  = res_r.left_pwm;
  assign out_right_pwm = res_r.right_pwm;
  assign out_left_ctl  = res_r.left_ctl;
  assign out_right_ctl = res_r.right_ctl;
  assign out_error     = res_r.error;

endmodule

[sv/dmdb_checker.sv]
// Port-level checks for the drive-brake PWM top level, bound to it.
module dmdb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_left_pwm,
  input logic out_right_pwm,
  input logic out_left_ctl,
  input logic out_right_ctl,
  input logic out_error
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // An empty result register never backs up the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  // A new result comes from an input transfer that passed the input register and then the result register
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid) && $past(rst_n)) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a matching input transfer");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_left_pwm)
      && $stable(out_right_pwm) && $stable(out_left_ctl)
      && $stable(out_right_ctl) && $stable(out_error)))
    else $error("stalled result changed");

endmodule

bind dual_motor_drive_brake_pwm_top dmdb_checker u_dmdb_checker (.*);

[test/dual_motor_drive_brake_pwm_top_test.sv]
// Self-checking testbench for the two-motor drive-brake PWM block with its own pin-level predictor.
module dual_motor_drive_brake_pwm_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dmdb_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 40;
  localparam int TIMEOUT_NS = 2_000_000;

  // Motor numbers on the motor field
  localparam logic [1:0] MOTOR_LEFT = 2'd0;
  localparam logic [1:0] MOTOR_RIGHT = 2'd1;
  localparam logic [1:0] MOTOR_BAD_LO = 2'd2;
  localparam logic [1:0] MOTOR_BAD_HI = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_NOP;
  logic [1:0] in_motor = MOTOR_LEFT;
  logic [7:0] in_value = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_left_pwm;
  logic out_right_pwm;
  logic out_left_ctl;
  logic out_right_ctl;
  logic out_error;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  // Predicted drive state
  logic [15:0] hp_model = HALF_PERIOD_RESET;
  logic [15:0] pwm_count = 16'd0;
  logic count_down = 1'b0;
  logic [15:0] cmp_active [2] = '{16'd0, 16'd0};
  logic [15:0] cmp_pending [2] = '{16'd0, 16'd0};
  mode_t mode_active [2] = '{MODE_NORMAL, MODE_NORMAL};
  mode_t mode_pending [2] = '{MODE_NORMAL, MODE_NORMAL};
  logic reverse [2] = '{1'b0, 1'b0};
  logic level [2] = '{1'b0, 1'b0};

  result_t expected_pins [$];
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int input_stall_cycles = 0;
  int hp_settings = 0;
  bit sender_gaps = 1'b1;
  bit receiver_stalls = 1'b1;
  bit long_hold_req = 1'b0;

  dual_motor_drive_brake_pwm_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_motor     (in_motor),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left_pwm (out_left_pwm),
    .out_right_pwm(out_right_pwm),
    .out_left_ctl (out_left_ctl),
    .out_right_ctl(out_right_ctl),
    .out_error    (out_error),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Update the predicted state for one command and return the pins after it
  task automatic apply_command(input cmd_t c, input logic [1:0] mot, input logic [7:0] v,
                               output result_t pins);
    int duty;
    int hp_i;
    int m;
    logic stepped_up;
    logic stepped_down;
    logic bad_motor;
    bad_motor = 1'b0;
    stepped_up = 1'b0;
    stepped_down = 1'b0;
    case (c)
      CMD_TICK: begin
        if (!count_down) begin
          if (pwm_count < hp_model) begin
            pwm_count = pwm_count + 16'd1;
            stepped_up = 1'b1;
          end
          // top may have been lowered below the count: turn around in place
          if (pwm_count >= hp_model) count_down = 1'b1;
        end else begin
          if (pwm_count != 16'd0) begin
            pwm_count = pwm_count - 16'd1;
            stepped_down = 1'b1;
          end
          if (pwm_count == 16'd0) count_down = 1'b0;
        end
        // buffered duty and mode load at counter zero
        if (pwm_count == 16'd0) begin
          for (m = 0; m < 2; m++) begin
            cmp_active[m] = cmp_pending[m];
            mode_active[m] = mode_pending[m];
          end
        end
        for (m = 0; m < 2; m++) begin
          case (mode_active[m])
            MODE_LOW: if (pwm_count == 16'd0) level[m] = 1'b0;
            MODE_HIGH: if (pwm_count == 16'd0) level[m] = 1'b1;
            default: begin
              if (pwm_count == cmp_active[m]) begin
                if (stepped_up) level[m] = 1'b1;
                else if (stepped_down) level[m] = 1'b0;
              end
            end
          endcase
        end
      end
      CMD_DUTY: begin
        if (mot > MOTOR_RIGHT) begin
          bad_motor = 1'b1;
        end else begin
          duty = (v > 8'(DUTY_FULL)) ? int'(DUTY_FULL) : int'(v);
          hp_i = int'(hp_model);
          if (duty == 0) begin
            mode_pending[mot[0]] = MODE_LOW;
          end else if (duty == int'(DUTY_FULL)) begin
            mode_pending[mot[0]] = MODE_HIGH;
          end else begin
            mode_pending[mot[0]] = MODE_NORMAL;
            cmp_pending[mot[0]] = 16'(hp_i - (hp_i * duty) / int'(DUTY_FULL));
          end
        end
      end
      CMD_DIR: begin
        if (mot > MOTOR_RIGHT) bad_motor = 1'b1;
        else if (v == DIR_FWD) reverse[mot[0]] = 1'b0;
        else if (v == DIR_BWD) reverse[mot[0]] = 1'b1;
      end
      default: ;
    endcase
    pins.left_pwm = level[0] ^ reverse[0];
    pins.right_pwm = level[1] ^ reverse[1];
    pins.left_ctl = reverse[0];
    pins.right_ctl = reverse[1];
    pins.error = bad_motor;
  endtask

  // Offer one command, wait for its transfer and queue the predicted pins
  task automatic send_cmd(input cmd_t c, input logic [1:0] mot, input logic [7:0] v);
    result_t want;
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_motor <= mot;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_command(c, mot, v, want);
    expected_pins.push_back(want);
    items_sent++;
  endtask

  // Stop offering and let every queued result come out
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the half period while nothing is in flight
  task automatic write_half_period(input logic [15:0] hp);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= hp;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hp_model = hp;
    hp_settings++;
  endtask

  // Errors, no-ops, saturation, force modes and direction handling
  task automatic test_commands();
    send_cmd(CMD_NOP, MOTOR_BAD_HI, 8'hFF);
    send_cmd(CMD_DUTY, MOTOR_BAD_LO, 8'd50);
    send_cmd(CMD_DIR, MOTOR_BAD_HI, DIR_BWD);
    send_cmd(CMD_DUTY, MOTOR_LEFT, 8'd101);
    send_cmd(CMD_DUTY, MOTOR_RIGHT, 8'd0);
    write_half_period(16'd4);
    repeat (8) send_cmd(CMD_TICK, MOTOR_BAD_HI, 8'hAA);
    send_cmd(CMD_DIR, MOTOR_LEFT, DIR_BWD);
    send_cmd(CMD_DIR, MOTOR_RIGHT, 8'd2);
    send_cmd(CMD_DIR, MOTOR_RIGHT, 8'hFF);
    send_cmd(CMD_DUTY, MOTOR_LEFT, 8'd1);
    send_cmd(CMD_DUTY, MOTOR_RIGHT, 8'd99);
    send_cmd(CMD_DIR, MOTOR_RIGHT, DIR_BWD);
    send_cmd(CMD_DIR, MOTOR_RIGHT, DIR_FWD);
    repeat (8) send_cmd(CMD_TICK, MOTOR_LEFT, 8'h55);
    drain();
  endtask

  // Long output hold while ticks keep coming, so the input side backs up
  task automatic test_output_hold();
    long_hold_req = 1'b1;
    repeat (24) send_cmd(CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    drain();
  endtask

  // Random commands over a range of half periods, mostly ticks
  task automatic test_random_phases();
    logic [15:0] plan [12];
    int n;
    int pick;
    int p;
    cmd_t c;
    logic [1:0] mot;
    logic [7:0] v;
    plan = '{16'd1, 16'd2, 16'd3, 16'd5, 16'd625, 16'd65535,
             16'd9, 16'd13, 16'd24, 16'd40, 16'd6, 16'd17};
    for (p = 0; p < 12; p++) begin
      write_half_period(plan[p]);
      n = (plan[p] == 16'd65535) ? 60 : (plan[p] == 16'd625) ? 250 : 160;
      sender_gaps = (p < 11) && (p % 3 != 1);
      receiver_stalls = (p < 11) && (p % 3 != 2);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        mot = 2'($urandom_range(0, 3));
        v = 8'($urandom_range(0, 255));
        if (pick < 78) begin
          c = CMD_TICK;
        end else if (pick < 90) begin
          c = CMD_DUTY;
          if ($urandom_range(0, 7) != 0) mot[1] = 1'b0;
          case ($urandom_range(0, 9))
            0: v = 8'd0;
            1: v = 8'd100;
            2: v = 8'($urandom_range(101, 255));
            default: v = 8'($urandom_range(1, 99));
          endcase
        end else if (pick < 96) begin
          c = CMD_DIR;
          if ($urandom_range(0, 7) != 0) mot[1] = 1'b0;
          if ($urandom_range(0, 4) != 0) v = $urandom_range(0, 1) ? DIR_BWD : DIR_FWD;
        end else begin
          c = CMD_NOP;
        end
        send_cmd(c, mot, v);
      end
    end
    drain();
  endtask

  // Receiver: random stall bursts, or one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic flag_mismatch(input string field, input logic want, input logic got);
    $display("%0t: %s mismatch, expected %b, actual %b", $time, field, want, got);
    mismatches++;
  endtask

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      got.left_pwm = out_left_pwm;
      got.right_pwm = out_right_pwm;
      got.left_ctl = out_left_ctl;
      got.right_ctl = out_right_ctl;
      got.error = out_error;
      if (expected_pins.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, got);
        mismatches++;
      end else begin
        want = expected_pins.pop_front();
        results_checked++;
        if (got.left_pwm !== want.left_pwm)
          flag_mismatch("left_pwm", want.left_pwm, got.left_pwm);
        if (got.right_pwm !== want.right_pwm)
          flag_mismatch("right_pwm", want.right_pwm, got.right_pwm);
        if (got.left_ctl !== want.left_ctl)
          flag_mismatch("left_ctl", want.left_ctl, got.left_ctl);
        if (got.right_ctl !== want.right_ctl)
          flag_mismatch("right_ctl", want.right_ctl, got.right_ctl);
        if (got.error !== want.error)
          flag_mismatch("error", want.error, got.error);
      end
    end
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, expected_pins.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_commands();
    test_output_hold();
    test_random_phases();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d commands and %0d results over %0d half-period settings (1 to 65535).",
             items_sent, results_checked, hp_settings);
    $display("Input side was held off on %0d cycles, including one long output hold.",
             input_stall_cycles);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/dmdb_pkg.sv
sv/dmdb_in_stage.sv
sv/dmdb_engine.sv
sv/dmdb_out_stage.sv
sv/dual_motor_drive_brake_pwm_top.sv
sv/dmdb_checker.sv
test/dual_motor_drive_brake_pwm_top_test.sv
